### rtl/core/hlva_pkg.sv
// Shared types, widths and constants of the Hough line vote accumulator.
package hlva_pkg;

	// Default geometry
	localparam int DEF_NUM_ANGLES = 180;
	localparam int DEF_NUM_RHO    = 1024;
	localparam int DEF_COORD_BITS = 8;

	// Fixed field widths of the item and result ports
	localparam int FUNC_W      = 2;
	localparam int POINT_W     = 8;
	localparam int ANGLE_IDX_W = 8;
	localparam int RHO_IDX_W   = 10;
	localparam int COUNT_W     = 17;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Trig table format: Q2.14
	localparam int TRIG_W = 16;
	localparam int FRAC_W = 14;

	// Series constants for building the trig table, Q30
	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam int     SERIES_TERMS = 14;
	localparam longint SIN_DIV [SERIES_TERMS] = '{
		6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812
	};
	localparam longint COS_DIV [SERIES_TERMS] = '{
		2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756
	};

	typedef enum logic [FUNC_W-1:0] {
		FN_VOTE  = 2'd0,
		FN_READ  = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VOTE,
		ST_READ,
		ST_RESULT
	} hlva_state_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_pair_t;

endpackage

### rtl/core/hlva_trig_rom.sv
// Cosine and sine table in Q2.14, one registered read per cycle.
module hlva_trig_rom
	import hlva_pkg::*;
#(
	parameter int NUM_ANGLES = DEF_NUM_ANGLES
) (
	input  logic                            clk,
	input  logic [$clog2(NUM_ANGLES)-1:0]   rd_addr,
	output trig_pair_t                      rd_data
);

	trig_pair_t rom_tab [NUM_ANGLES];
	trig_pair_t trig_q;

	// Round to nearest, ties to even, dropping 16 fraction bits
	function automatic longint rne_shift16(input longint v);
		logic   neg;
		longint mag;
		longint q;
		longint rem;
		neg = (v < 0);
		mag = neg ? -v : v;
		q   = mag >>> 16;
		rem = mag & 64'sd65535;
		if (rem > 64'sd32768 || (rem == 64'sd32768 && q[0])) begin
			q = q + 64'sd1;
		end
		return neg ? -q : q;
	endfunction

	// Integer Taylor series in Q30, folded into the first quadrant
	function automatic trig_pair_t trig_entry(input int n);
		longint     m;
		longint     t;
		longint     t2;
		longint     st;
		longint     ct;
		longint     s;
		longint     c;
		logic       flip;
		trig_pair_t e;
		m    = longint'(n);
		flip = 1'b0;
		if (2 * n > NUM_ANGLES) begin
			m    = longint'(NUM_ANGLES - n);
			flip = 1'b1;
		end
		t  = (PI_Q30 * m) / NUM_ANGLES;
		t2 = (t * t) >>> 30;
		st = t;
		ct = ONE_Q30;
		s  = t;
		c  = ONE_Q30;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			st = ((st * t2) >>> 30) / SIN_DIV[k];
			ct = ((ct * t2) >>> 30) / COS_DIV[k];
			if ((k & 1) == 0) begin
				s = s - st;
				c = c - ct;
			end else begin
				s = s + st;
				c = c + ct;
			end
		end
		if (flip) begin
			c = -c;
		end
		e.cos_v = TRIG_W'(rne_shift16(c));
		e.sin_v = TRIG_W'(rne_shift16(s));
		return e;
	endfunction

	for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_rom
		assign rom_tab[g] = trig_entry(g);
	end

	always_ff @(posedge clk) begin
		trig_q <= rom_tab[rd_addr];
	end

	assign rd_data = trig_q;

endmodule

### rtl/core/hough_line_vote_accumulator.sv
// Hough line vote accumulator: vote, read and clear over a memory of bin counts.
//
// One item is handled at a time. A vote item walks every angle index, one per
// cycle, through a four stage pipe (trig table read, x*cos and y*sin, sum with
// round-to-even and rho bias, bin memory read) and writes the incremented count
// back from the fourth. That is one bin read-modify-write per angle through the
// single read port and single write port of the bin memory. The vote result
// gives the largest count the vote produced, the lowest angle holding it, its
// biased rho, and whether it reaches the configured threshold. A read passes
// through the bin memory read register and the pending result before the
// output register; an unused func code goes from idle straight to the result
// state. A clear item sweeps the memory one bin per cycle before its result.
// Any result waits while a previous result is still held by out_stall. The
// same sweep runs after reset with in_stall high; configuration writes are
// taken during it. The result sits in an output register, so the next item
// may transfer while the previous result waits.
module hough_line_vote_accumulator
	import hlva_pkg::*;
#(
	parameter int NUM_ANGLES = DEF_NUM_ANGLES,
	parameter int NUM_RHO    = DEF_NUM_RHO,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,
	// item channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [FUNC_W-1:0]      func,
	input  logic [POINT_W-1:0]     point_x,
	input  logic [POINT_W-1:0]     point_y,
	input  logic [ANGLE_IDX_W-1:0] angle_index,
	input  logic [RHO_IDX_W-1:0]   rho_index,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COUNT_W-1:0]     bin_count,
	output logic [ANGLE_IDX_W-1:0] peak_angle,
	output logic [RHO_IDX_W-1:0]   peak_rho,
	output logic                   above_threshold
);

	localparam int ANG_W     = $clog2(NUM_ANGLES);
	localparam int RHO_W     = $clog2(NUM_RHO);
	localparam int MEM_AW    = ANG_W + RHO_W;
	localparam int MEM_DEPTH = NUM_ANGLES * (2 ** RHO_W);
	localparam int X_W       = (COORD_BITS < POINT_W) ? COORD_BITS : POINT_W;
	localparam int PROD_W    = X_W + 1 + TRIG_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int Q_W       = SUM_W - FRAC_W;
	localparam int RC_W      = ((Q_W > RHO_W + 1) ? Q_W : RHO_W + 1) + 2;
	localparam int BIAS      = (NUM_RHO - 1) / 2;
	localparam int PAD_A     = (ANG_W > ANGLE_IDX_W) ? ANG_W : ANGLE_IDX_W;
	localparam int PAD_R     = (RHO_W > RHO_IDX_W) ? RHO_W : RHO_IDX_W;

	localparam logic [FRAC_W-1:0] HALF_LSB = {1'b1, {(FRAC_W-1){1'b0}}};
	localparam logic [ANG_W-1:0]  LAST_ANG = ANG_W'(NUM_ANGLES - 1);
	localparam logic [RHO_W-1:0]  LAST_RHO = RHO_W'(NUM_RHO - 1);

	hlva_state_t state_q;
	hlva_state_t state_d;

	logic in_accept;
	logic load_out;
	logic vote_done;
	logic clr_last;

	// configuration
	logic [COUNT_W-1:0] thr_q;

	// item latches
	logic [X_W-1:0] x_q;
	logic [X_W-1:0] y_q;
	logic           rd_ok_q;
	logic [PAD_A-1:0] ai_pad;
	logic [PAD_R-1:0] ri_pad;

	// clear sweep
	logic [ANG_W-1:0] clr_ang_q;
	logic [RHO_W-1:0] clr_rho_q;
	logic             clr_emit_q;

	// vote pipe
	logic [ANG_W-1:0]         iss_ang_q;
	logic                     iss_on_q;
	trig_pair_t               trig_s1;
	logic                     v_s1;
	logic [ANG_W-1:0]         n_s1;
	logic signed [PROD_W-1:0] xs;
	logic signed [PROD_W-1:0] ys;
	logic signed [PROD_W-1:0] cs;
	logic signed [PROD_W-1:0] ss;
	logic                     v_s2;
	logic [ANG_W-1:0]         n_s2;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic signed [SUM_W-1:0]  sum_c;
	logic [Q_W-1:0]           q_c;
	logic [FRAC_W-1:0]        rem_c;
	logic                     rnd_up;
	logic signed [RC_W-1:0]   r_full;
	logic                     r_in_rng;
	logic                     ok_s3;
	logic [ANG_W-1:0]         n_s3;
	logic [RHO_W-1:0]         r_s3;
	logic                     ok_s4;
	logic [ANG_W-1:0]         n_s4;
	logic [RHO_W-1:0]         r_s4;
	logic [COUNT_W-1:0]       new_cnt;

	// bin memory
	logic [COUNT_W-1:0] vote_mem [MEM_DEPTH];
	logic               mem_we;
	logic               mem_re;
	logic [MEM_AW-1:0]  mem_waddr;
	logic [MEM_AW-1:0]  mem_raddr;
	logic [COUNT_W-1:0] mem_wdata;
	logic [COUNT_W-1:0] mem_rdata_q;

	// pending result
	logic [COUNT_W-1:0] res_count_q;
	logic [ANG_W-1:0]   res_ang_q;
	logic [RHO_W-1:0]   res_rho_q;
	logic               res_fv_q;
	logic [PAD_A-1:0]   res_ang_pad;
	logic [PAD_R-1:0]   res_rho_pad;

	// output register
	logic                   out_valid_q;
	logic [COUNT_W-1:0]     bin_count_q;
	logic [ANGLE_IDX_W-1:0] peak_angle_q;
	logic [RHO_IDX_W-1:0]   peak_rho_q;
	logic                   above_q;

	assign in_accept = in_valid && !in_stall;
	assign ai_pad    = PAD_A'(angle_index);
	assign ri_pad    = PAD_R'(rho_index);
	assign clr_last  = (clr_ang_q == LAST_ANG) && (clr_rho_q == LAST_RHO);
	assign vote_done = !iss_on_q && !v_s1 && !v_s2 && !ok_s3 && !ok_s4;

	//------------------------------------------------------------------
	// Control
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = {clr_ang_q, clr_rho_q};
		mem_raddr = {n_s3, r_s3};
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// zero one bin per cycle
				mem_we = 1'b1;
				if (clr_last) begin
					state_d = clr_emit_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (func)
						FN_VOTE:  state_d = ST_VOTE;
						FN_READ: begin
							state_d   = ST_READ;
							mem_re    = 1'b1;
							mem_raddr = {ai_pad[ANG_W-1:0], ri_pad[RHO_W-1:0]};
						end
						FN_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_RESULT;
					endcase
				end
			end
			ST_VOTE: begin
				// read at stage 3, write back at stage 4: always different angles
				mem_re    = ok_s3;
				mem_raddr = {n_s3, r_s3};
				mem_we    = ok_s4;
				mem_waddr = {n_s4, r_s4};
				mem_wdata = new_cnt;
				if (vote_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	//------------------------------------------------------------------
	// Configuration register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	//------------------------------------------------------------------
	// Clear sweep: row by row over the valid bins
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ang_q  <= '0;
			clr_rho_q  <= '0;
			clr_emit_q <= 1'b0;
		end else if (in_accept && func == FN_CLEAR) begin
			clr_ang_q  <= '0;
			clr_rho_q  <= '0;
			clr_emit_q <= 1'b1;
		end else if (state_q == ST_CLEAR) begin
			if (clr_rho_q == LAST_RHO) begin
				clr_rho_q <= '0;
				clr_ang_q <= (clr_ang_q == LAST_ANG) ? '0 : clr_ang_q + ANG_W'(1);
			end else begin
				clr_rho_q <= clr_rho_q + RHO_W'(1);
			end
		end
	end

	//------------------------------------------------------------------
	// Item latches
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q     <= point_x[X_W-1:0];
			y_q     <= point_y[X_W-1:0];
			rd_ok_q <= (32'(angle_index) < 32'(NUM_ANGLES)) &&
			           (32'(rho_index) < 32'(NUM_RHO));
		end
	end

	//------------------------------------------------------------------
	// Vote pipe
	//------------------------------------------------------------------
	// Angle issue counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_on_q  <= 1'b0;
			iss_ang_q <= '0;
		end else if (in_accept && func == FN_VOTE) begin
			iss_on_q  <= 1'b1;
			iss_ang_q <= '0;
		end else if (state_q == ST_VOTE && iss_on_q) begin
			iss_ang_q <= iss_ang_q + ANG_W'(1);
			if (iss_ang_q == LAST_ANG) begin
				iss_on_q <= 1'b0;
			end
		end
	end

	hlva_trig_rom #(
		.NUM_ANGLES(NUM_ANGLES)
	) u_trig_rom (
		.clk     (clk),
		.rd_addr (iss_ang_q),
		.rd_data (trig_s1)
	);

	// Stage 1 math: x*cos and y*sin
	assign xs = PROD_W'(x_q);
	assign ys = PROD_W'(y_q);
	assign cs = PROD_W'(trig_s1.cos_v);
	assign ss = PROD_W'(trig_s1.sin_v);

	// Stage 2 math: sum, round half to even, bias, range check
	assign sum_c    = SUM_W'(px_s2) + SUM_W'(py_s2);
	assign q_c      = sum_c[SUM_W-1:FRAC_W];
	assign rem_c    = sum_c[FRAC_W-1:0];
	assign rnd_up   = (rem_c > HALF_LSB) || (rem_c == HALF_LSB && q_c[0]);
	assign r_full   = RC_W'($signed(q_c)) + RC_W'(rnd_up) + RC_W'(BIAS);
	assign r_in_rng = !r_full[RC_W-1] && (r_full < RC_W'(NUM_RHO));

	// Stage 4 math: saturating increment
	assign new_cnt = (mem_rdata_q == COUNT_MAX) ? mem_rdata_q : mem_rdata_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			ok_s3 <= 1'b0;
			ok_s4 <= 1'b0;
		end else begin
			v_s1  <= (state_q == ST_VOTE) && iss_on_q;
			v_s2  <= v_s1;
			ok_s3 <= v_s2 && r_in_rng;
			ok_s4 <= ok_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s1  <= iss_ang_q;
		n_s2  <= n_s1;
		px_s2 <= xs * cs;
		py_s2 <= ys * ss;
		n_s3  <= n_s2;
		r_s3  <= r_full[RHO_W-1:0];
		n_s4  <= n_s3;
		r_s4  <= r_s3;
	end

	//------------------------------------------------------------------
	// Bin memory: one write port, one registered read port
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vote_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= vote_mem[mem_raddr];
		end
	end

	//------------------------------------------------------------------
	// Pending result
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_count_q <= '0;
			res_ang_q   <= '0;
			res_rho_q   <= '0;
			res_fv_q    <= (func == FN_VOTE) || (func == FN_READ);
		end else if (state_q == ST_READ) begin
			res_count_q <= rd_ok_q ? mem_rdata_q : '0;
		end else if (state_q == ST_VOTE && ok_s4 && new_cnt > res_count_q) begin
			// strictly larger only: keep the lowest angle on a tie
			res_count_q <= new_cnt;
			res_ang_q   <= n_s4;
			res_rho_q   <= r_s4;
		end
	end

	assign res_ang_pad = PAD_A'(res_ang_q);
	assign res_rho_pad = PAD_R'(res_rho_q);

	//------------------------------------------------------------------
	// Output register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bin_count_q  <= res_count_q;
			peak_angle_q <= res_ang_pad[ANGLE_IDX_W-1:0];
			peak_rho_q   <= res_rho_pad[RHO_IDX_W-1:0];
			above_q      <= res_fv_q && (res_count_q >= thr_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign bin_count       = bin_count_q;
	assign peak_angle      = peak_angle_q;
	assign peak_rho        = peak_rho_q;
	assign above_threshold = above_q;

endmodule

### bench/hough_line_vote_accumulator_test.sv
// Self-checking testbench for the Hough line vote accumulator: vote, read and clear items.
module hough_line_vote_accumulator_test
	import hlva_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLES   = DEF_NUM_ANGLES;
	localparam int RHOS     = DEF_NUM_RHO;
	localparam int RHO_BIAS = (RHOS - 1) / 2;
	localparam int COUNT_TOP = 131071;

	// Q30 constants for the trig table, kept apart from the design's own copy
	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam longint UNIT_Q30      = 64'sd1073741824;

	// func code the block leaves unused: it answers with an all-zero result
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam int IDLE_PCT      = 36;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 286;
	localparam int TAIL_CYCLES   = 200;

	// What the driver does with the head of its queue: send an item, wait for
	// every result to come back, or wait and then write the threshold.
	typedef enum logic [1:0] {
		ACT_ITEM,
		ACT_DRAIN,
		ACT_THRESHOLD
	} action_t;

	typedef struct packed {
		action_t                kind;
		logic [FUNC_W-1:0]      fn;
		logic [POINT_W-1:0]     x;
		logic [POINT_W-1:0]     y;
		logic [ANGLE_IDX_W-1:0] ang;
		logic [RHO_IDX_W-1:0]   rho;
		logic [COUNT_W-1:0]     thr;
		logic                   calm;
	} job_t;

	typedef struct packed {
		logic [COUNT_W-1:0]     count;
		logic [ANGLE_IDX_W-1:0] angle;
		logic [RHO_IDX_W-1:0]   rho;
		logic                   flag;
	} tally_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [COUNT_W-1:0]     cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [FUNC_W-1:0]      func = FN_VOTE;
	logic [POINT_W-1:0]     point_x = '0;
	logic [POINT_W-1:0]     point_y = '0;
	logic [ANGLE_IDX_W-1:0] angle_index = '0;
	logic [RHO_IDX_W-1:0]   rho_index = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [COUNT_W-1:0]     bin_count;
	logic [ANGLE_IDX_W-1:0] peak_angle;
	logic [RHO_IDX_W-1:0]   peak_rho;
	logic                   above_threshold;

	// Mirror of the block: trig table, bin counts and threshold
	int                 cos_q14 [ANGLES];
	int                 sin_q14 [ANGLES];
	bit [COUNT_W-1:0]   bin_model [ANGLES*RHOS];
	logic [COUNT_W-1:0] threshold_now = COUNT_W'(1);

	job_t               job_queue [$];
	tally_t             tally_queue [$];
	logic [POINT_W-1:0] voted_x [$];
	logic [POINT_W-1:0] voted_y [$];

	bit item_taken = 1'b0;
	bit steady = 1'b0;
	bit calm_fill = 1'b0;
	int settle = 0;
	int fail_count = 0;

	always #5 clk = ~clk;

	hough_line_vote_accumulator #(
		.NUM_ANGLES(ANGLES),
		.NUM_RHO(RHOS),
		.COORD_BITS(DEF_COORD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.point_x(point_x),
		.point_y(point_y),
		.angle_index(angle_index),
		.rho_index(rho_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bin_count(bin_count),
		.peak_angle(peak_angle),
		.peak_rho(peak_rho),
		.above_threshold(above_threshold)
	);

	// Divide by 2^sh and round to nearest, ties to even, on the magnitude.
	function automatic longint round_half_even(longint v, int sh);
		longint mag, q, rem, half;
		mag = (v < 0) ? -v : v;
		q = mag >>> sh;
		rem = mag & ((64'sd1 <<< sh) - 1);
		half = 64'sd1 <<< (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		return (v < 0) ? -q : q;
	endfunction

	// Unbiased rho of point (x, y) at angle index n.
	function automatic int rho_of(logic [POINT_W-1:0] x, logic [POINT_W-1:0] y, int n);
		longint acc;
		acc = longint'(x) * cos_q14[n] + longint'(y) * sin_q14[n];
		return int'(round_half_even(acc, FRAC_W));
	endfunction

	// Apply one item to the mirrored store and return the result it must produce.
	function automatic tally_t tally_item(logic [FUNC_W-1:0] fn, logic [POINT_W-1:0] x,
			logic [POINT_W-1:0] y, logic [ANGLE_IDX_W-1:0] ang,
			logic [RHO_IDX_W-1:0] rho);
		tally_t res;
		bit hit;
		int n, r, slot;
		res = '0;
		hit = 1'b0;
		case (fn)
		FN_VOTE: begin
			for (n = 0; n < ANGLES; n++) begin
				r = rho_of(x, y, n) + RHO_BIAS;
				// drop the vote for an angle whose rho lands outside the store
				if (r >= 0 && r < RHOS) begin
					slot = n * RHOS + r;
					if (bin_model[slot] < COUNT_TOP)
						bin_model[slot]++;
					// keep the lowest angle on ties
					if (!hit || bin_model[slot] > res.count) begin
						hit = 1'b1;
						res.count = bin_model[slot];
						res.angle = ANGLE_IDX_W'(n);
						res.rho = RHO_IDX_W'(r);
					end
				end
			end
			res.flag = res.count >= threshold_now;
		end
		FN_READ: begin
			if (ang < ANGLES && rho < RHOS)
				res.count = bin_model[ang * RHOS + rho];
			res.flag = res.count >= threshold_now;
		end
		FN_CLEAR: begin
			foreach (bin_model[j])
				bin_model[j] = '0;
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic queue_item(logic [FUNC_W-1:0] fn, int x, int y, int ang, int rho);
		job_t job;
		job = '0;
		job.kind = ACT_ITEM;
		job.fn = fn;
		job.x = POINT_W'(x);
		job.y = POINT_W'(y);
		job.ang = ANGLE_IDX_W'(ang);
		job.rho = RHO_IDX_W'(rho);
		job.calm = calm_fill;
		job_queue.insert(job_queue.size(), job);
		// remember voted points so later reads can aim at bins that hold counts
		if (fn == FN_VOTE) begin
			voted_x.insert(voted_x.size(), job.x);
			voted_y.insert(voted_y.size(), job.y);
		end
	endtask

	task automatic queue_pause(action_t kind, int thr);
		job_t job;
		job = '0;
		job.kind = kind;
		job.thr = COUNT_W'(thr);
		job.calm = calm_fill;
		job_queue.insert(job_queue.size(), job);
	endtask

	// Driver: change inputs on the falling edge. Hold a stalled transfer, idle
	// at random unless the current stretch is calm, and write the threshold
	// only once every expected result has come back.
	always @(negedge clk) begin
		job_t head;
		logic next_valid, next_we;
		next_valid = in_valid && !item_taken;
		next_we = 1'b0;
		if (arst_n && !next_valid && job_queue.size() != 0) begin
			head = job_queue[0];
			steady = head.calm;
			if (head.kind == ACT_ITEM) begin
				if (steady || $urandom_range(99) >= IDLE_PCT) begin
					func <= head.fn;
					point_x <= head.x;
					point_y <= head.y;
					angle_index <= head.ang;
					rho_index <= head.rho;
					next_valid = 1'b1;
					void'(job_queue.pop_front());
				end
			end else if (tally_queue.size() != 0) begin
				settle = 0;
			end else if (settle < SETTLE_CYCLES) begin
				settle++;
			end else begin
				settle = 0;
				if (head.kind == ACT_THRESHOLD) begin
					next_we = 1'b1;
					cfg_wdata <= head.thr;
					threshold_now = head.thr;
				end
				void'(job_queue.pop_front());
			end
		end
		in_valid <= next_valid;
		cfg_we <= next_we;
		if (arst_n)
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Monitor: sample on the rising edge. Check a result transfer against the
	// oldest expectation first, then predict for an item transfer.
	always @(posedge clk) begin
		tally_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.count = bin_count;
				got.angle = peak_angle;
				got.rho = peak_rho;
				got.flag = above_threshold;
				if (tally_queue.size() == 0) begin
					report_mismatch($sformatf("result with no item pending, bin_count %0d",
						bin_count));
				end else begin
					want = tally_queue.pop_front();
					if (got.count !== want.count)
						report_mismatch($sformatf("bin_count %0d, expected %0d",
							got.count, want.count));
					if (got.angle !== want.angle)
						report_mismatch($sformatf("peak_angle %0d, expected %0d",
							got.angle, want.angle));
					if (got.rho !== want.rho)
						report_mismatch($sformatf("peak_rho %0d, expected %0d",
							got.rho, want.rho));
					if (got.flag !== want.flag)
						report_mismatch($sformatf("above_threshold %0b, expected %0b",
							got.flag, want.flag));
				end
			end
			item_taken = in_valid && !in_stall;
			if (item_taken)
				tally_queue.insert(tally_queue.size(),
					tally_item(func, point_x, point_y, angle_index, rho_index));
		end
	end

	// Reset: start low, release on a falling edge.
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Guard against a hang; the reset sweep, two clears and the votes fill a normal run.
	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus: build the trig table, fill the item queue, then wait for drain.
	initial begin
		longint t, t2, st, ct, s, c;
		int n, k, m, ph, i, pick, r, lx, ly;
		int x0 [4];
		int y0 [4];
		int dx [4];
		int dy [4];
		int thr;

		// Taylor series in Q30 over the first quadrant; mirror obtuse angles
		// by negating the cosine, then round to Q2.14.
		for (n = 0; n < ANGLES; n++) begin
			m = (2 * n > ANGLES) ? ANGLES - n : n;
			t = (HALF_TURN_Q30 * m) / ANGLES;
			t2 = (t * t) >>> 30;
			st = t;
			ct = UNIT_Q30;
			s = t;
			c = UNIT_Q30;
			for (k = 1; k <= 14; k++) begin
				st = ((st * t2) >>> 30) / ((2 * k) * (2 * k + 1));
				ct = ((ct * t2) >>> 30) / ((2 * k - 1) * (2 * k));
				if (k % 2) begin
					s -= st;
					c -= ct;
				end else begin
					s += st;
					c += ct;
				end
			end
			if (2 * n > ANGLES)
				c = -c;
			cos_q14[n] = int'(round_half_even(c, 16));
			sin_q14[n] = int'(round_half_even(s, 16));
		end

		// Directed: corner points, a repeated hit, reads in and out of range,
		// the unused func code, one clear, and threshold at zero and at maximum.
		queue_item(FN_VOTE, 0, 0, 255, 1023);
		queue_item(FN_VOTE, 255, 255, 0, 0);
		queue_item(FN_VOTE, 255, 0, 179, 511);
		queue_item(FN_VOTE, 0, 255, 90, 1);
		queue_item(FN_VOTE, 0, 0, 0, 0);
		queue_item(FN_READ, 0, 0, 0, RHO_BIAS);
		queue_item(FN_READ, 255, 255, 45, rho_of(8'd255, 8'd255, 45) + RHO_BIAS);
		queue_item(FN_READ, 0, 0, ANGLES - 1, RHOS - 1);
		queue_item(FN_READ, 0, 0, ANGLES, RHO_BIAS);
		queue_item(FN_READ, 255, 255, 255, 0);
		queue_item(FN_UNUSED, 255, 255, 255, 1023);
		queue_item(FN_VOTE, 128, 77, 17, 300);
		queue_item(FN_CLEAR, 0, 0, 0, 0);
		queue_item(FN_READ, 0, 0, 0, RHO_BIAS);
		queue_item(FN_VOTE, 0, 0, 0, 0);
		queue_pause(ACT_THRESHOLD, 0);
		queue_item(FN_VOTE, 1, 1, 0, 0);
		queue_item(FN_READ, 0, 0, 200, 5);
		queue_item(FN_UNUSED, 0, 0, 0, 0);
		queue_pause(ACT_THRESHOLD, COUNT_TOP);
		queue_item(FN_VOTE, 0, 0, 0, 0);
		queue_item(FN_READ, 0, 0, 0, RHO_BIAS);

		// Random phases, each under its own threshold. Most votes fall on a
		// few lines so bins build up real peaks; reads mostly aim at hit bins.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: thr = $urandom_range(6, 2);
			1: thr = $urandom_range(40, 7);
			2: thr = 1;
			3: thr = $urandom_range(COUNT_TOP, 1);
			default: thr = $urandom_range(12, 2);
			endcase
			queue_pause(ACT_THRESHOLD, thr);
			// one phase runs with no idling on either side
			calm_fill = (ph == 2);
			for (k = 0; k < 4; k++) begin
				x0[k] = $urandom_range(255);
				y0[k] = $urandom_range(255);
				dx[k] = int'($urandom_range(4)) - 2;
				dy[k] = int'($urandom_range(4)) - 2;
			end
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 1 && i == PHASE_ITEMS / 2)
					queue_pause(ACT_DRAIN, 0);
				pick = $urandom_range(99);
				if (ph == 3 && i == PHASE_ITEMS / 2) begin
					queue_item(FN_CLEAR, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(1023));
				end else if (pick < 60) begin
					k = $urandom_range(3);
					r = $urandom_range(40);
					lx = x0[k] + r * dx[k];
					ly = y0[k] + r * dy[k];
					// fall back to the line's base point when the step runs off the image
					if (lx < 0 || lx > 255 || ly < 0 || ly > 255) begin
						lx = x0[k];
						ly = y0[k];
					end
					queue_item(FN_VOTE, lx, ly, $urandom_range(255), $urandom_range(1023));
				end else if (pick < 75) begin
					queue_item(FN_VOTE, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(1023));
				end else if (pick < 86) begin
					r = $urandom_range(voted_x.size() - 1);
					n = $urandom_range(ANGLES - 1);
					queue_item(FN_READ, $urandom_range(255), $urandom_range(255), n,
						rho_of(voted_x[r], voted_y[r], n) + RHO_BIAS);
				end else if (pick < 96) begin
					queue_item(FN_READ, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(1023));
				end else begin
					queue_item(FN_UNUSED, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(1023));
				end
			end
		end

		while (job_queue.size() != 0 || in_valid || tally_queue.size() != 0)
			@(posedge clk);
		// let any stray result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
